FILE: hw/rtl/gpio_rb_pkg.sv
// ----------------------------------------------------------------------------
// gpio_rb_pkg: shared types and constants of the GPIO register bank
// Word map, pull mode codes, field widths and the transfer structs.
// ----------------------------------------------------------------------------
package gpio_rb_pkg;

    localparam int unsigned DataWidth    = 32;
    localparam int unsigned WordWidth    = 6;
    localparam int unsigned FselWords    = 4;
    localparam int unsigned FselBits     = 30;
    localparam int unsigned PinsPerFsel  = 10;
    localparam int unsigned FselField    = 3;
    localparam int unsigned PinCountDef  = 32;

    // register word addresses
    localparam logic [WordWidth-1:0] WORD_SET    = 6'd7;
    localparam logic [WordWidth-1:0] WORD_CLR    = 6'd10;
    localparam logic [WordWidth-1:0] WORD_LEV    = 6'd13;
    localparam logic [WordWidth-1:0] WORD_PUD    = 6'd37;
    localparam logic [WordWidth-1:0] WORD_PUDCLK = 6'd38;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // pull mode codes; the fourth code is reserved and leaves pulls alone
    localparam logic [1:0] PULL_NONE = 2'd0;
    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    localparam logic [FselField-1:0] FSEL_OUTPUT = 3'b001;

    typedef struct packed {
        logic                 opcode;
        logic [WordWidth-1:0] word_index;
        logic [DataWidth-1:0] write_data;
        logic [DataWidth-1:0] pin_levels;
    } t_access;

    typedef struct packed {
        logic [DataWidth-1:0] read_data;
        logic [DataWidth-1:0] output_latch;
        logic [DataWidth-1:0] output_enable;
        logic [DataWidth-1:0] pull_up_pins;
        logic [DataWidth-1:0] pull_down_pins;
    } t_result;

endpackage

FILE: hw/rtl/gpio_register_bank.sv
// ----------------------------------------------------------------------------
// gpio_register_bank: register-level GPIO block for one pin bank
// Function select, set/clear output latch, level read and pull control.
// ----------------------------------------------------------------------------
// Path from input transfer to result valid: input register, then
// decode/update into the result register.
// Throughput: one access per cycle while the output is not stalled (i_stall).
// Reset: synchronous active low; all pins inputs, latch, pull mode and
// pull masks cleared, both stages empty.
module gpio_register_bank #(
    parameter int unsigned PIN_COUNT = gpio_rb_pkg::PinCountDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [5:0]  i_word_index,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_pin_levels,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic [31:0] o_output_latch,
    output logic [31:0] o_output_enable,
    output logic [31:0] o_pull_up_pins,
    output logic [31:0] o_pull_down_pins
);

    gpio_rb_pkg::t_access w_in_item;
    gpio_rb_pkg::t_access w_stage_item;
    gpio_rb_pkg::t_result w_result;
    logic                 w_stage_valid;
    logic                 w_take;

    assign w_in_item.opcode     = i_opcode;
    assign w_in_item.word_index = i_word_index;
    assign w_in_item.write_data = i_write_data;
    assign w_in_item.pin_levels = i_pin_levels;

    gpio_rb_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (w_in_item),
        .o_stall (o_stall),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item),
        .i_take  (w_take)
    );

    gpio_rb_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_stage_valid),
        .i_item   (w_stage_item),
        .o_take   (w_take),
        .o_valid  (o_valid),
        .o_result (w_result),
        .i_stall  (i_stall)
    );

    assign o_read_data      = w_result.read_data;
    assign o_output_latch   = w_result.output_latch;
    assign o_output_enable  = w_result.output_enable;
    assign o_pull_up_pins   = w_result.pull_up_pins;
    assign o_pull_down_pins = w_result.pull_down_pins;

endmodule

FILE: hw/rtl/gpio_rb_in_stage.sv
// ----------------------------------------------------------------------------
// gpio_rb_in_stage: input register of the GPIO register bank
// Holds one bus access; refills in the cycle the held access is taken.
// ----------------------------------------------------------------------------
module gpio_rb_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  gpio_rb_pkg::t_access i_item,
    output logic                o_stall,
    output logic                o_valid,
    output gpio_rb_pkg::t_access o_item,
    input  logic                i_take
);

    logic                 r_valid;
    logic                 n_valid;
    gpio_rb_pkg::t_access r_item;
    logic                 w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/gpio_rb_regs.sv
// ----------------------------------------------------------------------------
// gpio_rb_regs: register file and result register of the GPIO register bank
// Decodes one access, updates the bank state and registers the pin-side view.
// ----------------------------------------------------------------------------
module gpio_rb_regs #(
    parameter int unsigned PIN_COUNT = gpio_rb_pkg::PinCountDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gpio_rb_pkg::t_access i_item,
    output logic                 o_take,
    output logic                 o_valid,
    output gpio_rb_pkg::t_result o_result,
    input  logic                 i_stall
);

    localparam int unsigned DW = gpio_rb_pkg::DataWidth;
    localparam logic [DW-1:0] PinMask = DW'((64'd1 << PIN_COUNT) - 64'd1);

    logic [gpio_rb_pkg::FselBits-1:0] r_fsel [gpio_rb_pkg::FselWords];
    logic [gpio_rb_pkg::FselBits-1:0] n_fsel [gpio_rb_pkg::FselWords];
    logic [DW-1:0] r_latch, n_latch;
    logic [1:0]    r_pull_mode, n_pull_mode;
    logic [DW-1:0] r_pull_up, n_pull_up;
    logic [DW-1:0] r_pull_down, n_pull_down;
    logic          r_valid, n_valid;
    gpio_rb_pkg::t_result r_result, n_result;

    logic          w_write;
    logic          w_fsel_hit;
    logic [1:0]    w_fsel_idx;
    logic [DW-1:0] w_sel;
    logic [DW-1:0] w_rd;
    logic [DW-1:0] w_enable;

    assign o_take     = i_valid && (!r_valid || !i_stall);
    assign w_write    = i_item.opcode == gpio_rb_pkg::OP_WRITE;
    assign w_fsel_hit = i_item.word_index < gpio_rb_pkg::WordWidth'(gpio_rb_pkg::FselWords);
    assign w_fsel_idx = i_item.word_index[1:0];
    assign w_sel      = i_item.write_data & PinMask;

    // state update for the access in the input register
    always_comb begin
        n_fsel      = r_fsel;
        n_latch     = r_latch;
        n_pull_mode = r_pull_mode;
        n_pull_up   = r_pull_up;
        n_pull_down = r_pull_down;
        if (o_take && w_write) begin
            if (w_fsel_hit) begin
                n_fsel[w_fsel_idx] = i_item.write_data[gpio_rb_pkg::FselBits-1:0];
            end else if (i_item.word_index == gpio_rb_pkg::WORD_SET) begin
                n_latch = r_latch | w_sel;
            end else if (i_item.word_index == gpio_rb_pkg::WORD_CLR) begin
                n_latch = r_latch & ~w_sel;
            end else if (i_item.word_index == gpio_rb_pkg::WORD_PUD) begin
                n_pull_mode = i_item.write_data[1:0];
            end else if (i_item.word_index == gpio_rb_pkg::WORD_PUDCLK) begin
                unique case (r_pull_mode)
                    gpio_rb_pkg::PULL_NONE: begin
                        n_pull_up   = r_pull_up & ~w_sel;
                        n_pull_down = r_pull_down & ~w_sel;
                    end
                    gpio_rb_pkg::PULL_DOWN: begin
                        n_pull_up   = r_pull_up & ~w_sel;
                        n_pull_down = r_pull_down | w_sel;
                    end
                    gpio_rb_pkg::PULL_UP: begin
                        n_pull_up   = r_pull_up | w_sel;
                        n_pull_down = r_pull_down & ~w_sel;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // read path sees the state before this access
    always_comb begin
        w_rd = '0;
        if (!w_write) begin
            if (w_fsel_hit) begin
                w_rd = DW'(r_fsel[w_fsel_idx]);
            end else if (i_item.word_index == gpio_rb_pkg::WORD_LEV) begin
                w_rd = i_item.pin_levels & PinMask;
            end else if (i_item.word_index == gpio_rb_pkg::WORD_PUD) begin
                w_rd = DW'(r_pull_mode);
            end
        end
    end

    // pin p sits in word p/10 at bit 3*(p%10)
    for (genvar p = 0; p < DW; p++) begin : g_enable
        localparam int unsigned Word  = p / gpio_rb_pkg::PinsPerFsel;
        localparam int unsigned Shift = (p % gpio_rb_pkg::PinsPerFsel) * gpio_rb_pkg::FselField;
        assign w_enable[p] =
            n_fsel[Word][Shift +: gpio_rb_pkg::FselField] == gpio_rb_pkg::FSEL_OUTPUT;
    end

    always_comb begin
        n_result.read_data      = w_rd;
        n_result.output_latch   = n_latch & PinMask;
        n_result.output_enable  = w_enable & PinMask;
        n_result.pull_up_pins   = n_pull_up & PinMask;
        n_result.pull_down_pins = n_pull_down & PinMask;
    end

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_fsel      <= '{default: '0};
            r_latch     <= '0;
            r_pull_mode <= gpio_rb_pkg::PULL_NONE;
            r_pull_up   <= '0;
            r_pull_down <= '0;
        end else begin
            r_valid     <= n_valid;
            r_fsel      <= n_fsel;
            r_latch     <= n_latch;
            r_pull_mode <= n_pull_mode;
            r_pull_up   <= n_pull_up;
            r_pull_down <= n_pull_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
